### src/assert_macros.svh
// Assertion helpers shared by the store's modules.
// Each use expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked on every clock edge outside reset.
`define AMX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication checked on every clock edge outside reset.
`define AMX_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### src/amx_pkg.sv
package amx_pkg;

  localparam int ACT_W = 3;
  localparam int VTX_W = 4;
  localparam int CNT_W = 5;
  localparam int W_IN = 16;
  localparam int W_OUT = 16;

  localparam int DEF_MAX_VERTICES = 16;
  localparam int DEF_WEIGHT_BITS = 16;
  localparam logic [CNT_W-1:0] VC_RESET = 5'd16;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_SET    = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_ADD    = 3'd2,
    ACT_READ   = 3'd3,
    ACT_SUCC   = 3'd4,
    ACT_PRED   = 3'd5
  } action_e;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic [VTX_W-1:0]        source_vertex;
    logic [VTX_W-1:0]        dest_vertex;
    logic signed [W_IN-1:0]  weight;
  } req_t;

  typedef struct packed {
    logic                    status;
    logic                    found;
    logic [VTX_W-1:0]        neighbor_vertex;
    logic signed [W_OUT-1:0] result_weight;
    logic                    last;
  } rsp_t;

  typedef struct packed {
    logic [CNT_W-1:0] vertex_count;
  } cfg_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    action_e                 op;
    logic                    err;
    logic [VTX_W-1:0]        src;
    logic [VTX_W-1:0]        dst;
    logic signed [W_IN-1:0]  weight;
    logic [CNT_W-1:0]        n;
  } cmd_t;

endpackage

### src/amx_chan_if.sv
interface amx_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### src/adjacency_matrix_store_core.sv
// Channel   Dir   Payload                                           Handshake
// req_i     in    action, source_vertex, dest_vertex, weight        valid/ready
// rsp_o     out   status, found, neighbor_vertex, result_weight,    valid/ready
//                 last
// cfg_i     in    vertex_count                                      valid/ready (always ready)
//
// Point actions (set, remove, add, read) run in the back as one RAM read, then
// the write and the result. The RAM's single read port sets this.
// A scan of n vertices in use does one RAM read per vertex.
// After reset all MAX_VERTICES*MAX_VERTICES entries are swept to absent;
// req_i stays stalled during the sweep.
// A two-entry queue between front and back lets requests land while a scan runs;
// a full queue or the clearing sweep drops req_i.ready.
module adjacency_matrix_store_core #(
  parameter int MAX_VERTICES = amx_pkg::DEF_MAX_VERTICES,
  parameter int WEIGHT_BITS  = amx_pkg::DEF_WEIGHT_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  amx_chan_if.sink    req_i,
  amx_chan_if.sink    cfg_i,
  amx_chan_if.source  rsp_o
);
  logic          clearing;
  logic          q_full, q_empty;
  logic          push, pop;
  amx_pkg::cmd_t push_data, head;

  // Front: hold the vertex count, check indices, classify the action.
  amx_front #(
    .MaxVertices (MAX_VERTICES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_i       (cfg_i),
    .clearing_i  (clearing),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Queue: decouple acceptance from execution.
  amx_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head)
  );

  // Back: own the matrix RAM, run point updates and scans, drive results.
  amx_back #(
    .MaxVertices (MAX_VERTICES),
    .WeightBits  (WEIGHT_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_head_i   (head),
    .pop_o      (pop),
    .clearing_o (clearing),
    .rsp_o      (rsp_o)
  );
endmodule

### src/amx_ram.sv
module amx_ram #(
  parameter int Width = 16,
  parameter int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

### src/amx_queue.sv
`include "assert_macros.svh"

module amx_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  amx_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output amx_pkg::cmd_t head_o
);
  localparam int Depth = amx_pkg::QUEUE_DEPTH;
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  amx_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] bump(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wr_d  = push_i ? bump(wr_q) : wr_q;
    rd_d  = pop_i ? bump(rd_q) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  `AMX_ASSERT_IMPL(a_no_push_full, push_i, !full_o, "queue written while full")
  `AMX_ASSERT_IMPL(a_no_pop_empty, pop_i, !empty_o, "queue read while empty")
  `AMX_ASSERT(a_cnt_bound, cnt_q <= CntW'(Depth), "queue count past its depth")
endmodule

### src/amx_front.sv
module amx_front #(
  parameter int MaxVertices = amx_pkg::DEF_MAX_VERTICES
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  amx_chan_if.sink      req_i,
  amx_chan_if.sink      cfg_i,
  input  logic          clearing_i,
  input  logic          q_full_i,
  output logic          push_o,
  output amx_pkg::cmd_t push_data_o
);
  localparam int CW = amx_pkg::CNT_W;

  logic [CW-1:0] vc_q, vc_d;
  logic [CW-1:0] n_eff;
  logic          known, point, accept;

  assign cfg_i.ready = 1'b1;
  assign vc_d = (cfg_i.valid) ? cfg_i.payload.vertex_count : vc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= amx_pkg::VC_RESET;
    end else begin
      vc_q <= vc_d;
    end
  end

  // Hold off requests while the store is being cleared or the queue is full.
  assign req_i.ready = !q_full_i && !clearing_i;
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    case (req_i.payload.action)
      amx_pkg::ACT_SET, amx_pkg::ACT_REMOVE, amx_pkg::ACT_ADD, amx_pkg::ACT_READ: begin
        known = 1'b1;
        point = 1'b1;
      end
      amx_pkg::ACT_SUCC, amx_pkg::ACT_PRED: begin
        known = 1'b1;
        point = 1'b0;
      end
      default: begin
        known = 1'b0;
        point = 1'b0;
      end
    endcase
  end

  assign n_eff = (int'(vc_q) > MaxVertices) ? CW'(MaxVertices) : vc_q;

  always_comb begin
    push_data_o.op     = amx_pkg::action_e'(req_i.payload.action);
    push_data_o.err    = (CW'(req_i.payload.source_vertex) >= n_eff) ||
                         (point && (CW'(req_i.payload.dest_vertex) >= n_eff));
    push_data_o.src    = req_i.payload.source_vertex;
    push_data_o.dst    = req_i.payload.dest_vertex;
    push_data_o.weight = req_i.payload.weight;
    push_data_o.n      = n_eff;
  end

  // Drop unused action codes here; they never reach the back.
  assign push_o = accept && known;
endmodule

### src/amx_back.sv
`include "assert_macros.svh"

module amx_back #(
  parameter int MaxVertices = amx_pkg::DEF_MAX_VERTICES,
  parameter int WeightBits  = amx_pkg::DEF_WEIGHT_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  amx_pkg::cmd_t q_head_i,
  output logic          pop_o,
  output logic          clearing_o,
  amx_chan_if.source    rsp_o
);
  localparam int Depth = MaxVertices * MaxVertices;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW    = amx_pkg::CNT_W;
  localparam int VW    = amx_pkg::VTX_W;
  localparam int OW    = amx_pkg::W_OUT;
  localparam int SW    = ((WeightBits > OW) ? WeightBits : OW) + 1;
  localparam logic signed [SW-1:0] WMax   = SW'((64'sd1 <<< (WeightBits - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] OutMax = SW'((64'sd1 <<< (OW - 1)) - 64'sd1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PDATA = 3'd2;
  localparam logic [2:0] S_SDATA = 3'd3;
  localparam logic [2:0] S_SFIN  = 3'd4;

  logic [2:0]               state_q, state_d;
  amx_pkg::cmd_t            cmd_q, cmd_d;
  logic [CW-1:0]            idx_q, idx_d;
  logic [AW-1:0]            clr_q, clr_d;
  logic                     have_pend_q, have_pend_d;
  logic [VW-1:0]            pend_nb_q, pend_nb_d;
  logic signed [OW-1:0]     pend_w_q, pend_w_d;
  logic                     rsp_valid_q, rsp_valid_d;
  amx_pkg::rsp_t            rsp_q, rsp_d;

  logic                     out_free, present;
  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic signed [WeightBits-1:0] ram_wdata, rd, new_val;
  logic signed [SW-1:0]     sum_s, val_s;

  function automatic logic [AW-1:0] addr_of(amx_pkg::action_e op, logic [VW-1:0] s,
                                            logic [VW-1:0] d, logic [CW-1:0] i);
    logic [CW-1:0] row, col;
    case (op)
      amx_pkg::ACT_SUCC: begin
        row = CW'(s);
        col = i;
      end
      amx_pkg::ACT_PRED: begin
        row = i;
        col = CW'(s);
      end
      default: begin
        row = CW'(s);
        col = CW'(d);
      end
    endcase
    return AW'(row) * AW'(MaxVertices) + AW'(col);
  endfunction

  // Saturate a stored weight to the result width; absent reads as -1.
  function automatic logic signed [OW-1:0] to_rsp(logic signed [WeightBits-1:0] v);
    logic signed [SW-1:0] ext;
    ext = SW'(v);
    return (ext > OutMax) ? OW'(OutMax) : ext[OW-1:0];
  endfunction

  amx_ram #(
    .Width (WeightBits),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd)
  );

  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign present  = !rd[WeightBits-1];

  // New entry value for point actions.
  always_comb begin
    sum_s = SW'(rd) + SW'(cmd_q.weight);
    val_s = (cmd_q.op == amx_pkg::ACT_ADD) ? sum_s : SW'(cmd_q.weight);
    if (cmd_q.op == amx_pkg::ACT_REMOVE) begin
      new_val = '1;
    end else if (cmd_q.op == amx_pkg::ACT_READ) begin
      new_val = rd;
    end else if (val_s < 0) begin
      new_val = '1;
    end else if (val_s > WMax) begin
      new_val = WeightBits'(WMax);
    end else begin
      new_val = WeightBits'(val_s);
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    clr_d       = clr_q;
    have_pend_d = have_pend_q;
    pend_nb_d   = pend_nb_q;
    pend_w_d    = pend_w_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_d       = rsp_q;
    pop_o       = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = addr_of(q_head_i.op, q_head_i.src, q_head_i.dst, '0);
    ram_we      = 1'b0;
    ram_waddr   = addr_of(cmd_q.op, cmd_q.src, cmd_q.dst, idx_q);
    ram_wdata   = new_val;

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '1;
        if (clr_q == AW'(Depth - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (!q_empty_i) begin
          if (q_head_i.err) begin
            if (out_free) begin
              pop_o       = 1'b1;
              rsp_valid_d = 1'b1;
              rsp_d       = '{status: 1'b1, found: 1'b0, neighbor_vertex: '0,
                              result_weight: '1, last: 1'b1};
            end
          end else begin
            pop_o       = 1'b1;
            ram_re      = 1'b1;
            cmd_d       = q_head_i;
            idx_d       = '0;
            have_pend_d = 1'b0;
            if (q_head_i.op == amx_pkg::ACT_SUCC || q_head_i.op == amx_pkg::ACT_PRED) begin
              state_d = S_SDATA;
            end else begin
              state_d = S_PDATA;
            end
          end
        end
      end
      S_PDATA: begin
        if (out_free) begin
          ram_we      = (cmd_q.op != amx_pkg::ACT_READ);
          rsp_valid_d = 1'b1;
          rsp_d       = '{status: 1'b0, found: !new_val[WeightBits-1],
                          neighbor_vertex: cmd_q.dst, result_weight: to_rsp(new_val),
                          last: 1'b1};
          state_d     = S_IDLE;
        end
      end
      S_SDATA: begin
        // Stall only when a second arc shows up and the pending one cannot leave.
        if (!(present && have_pend_q && !out_free)) begin
          if (present && have_pend_q) begin
            rsp_valid_d = 1'b1;
            rsp_d       = '{status: 1'b0, found: 1'b1, neighbor_vertex: pend_nb_q,
                            result_weight: pend_w_q, last: 1'b0};
          end
          if (present) begin
            have_pend_d = 1'b1;
            pend_nb_d   = idx_q[VW-1:0];
            pend_w_d    = to_rsp(rd);
          end
          if (idx_q == cmd_q.n - CW'(1)) begin
            state_d = S_SFIN;
          end else begin
            idx_d     = idx_q + CW'(1);
            ram_re    = 1'b1;
            ram_raddr = addr_of(cmd_q.op, cmd_q.src, cmd_q.dst, idx_q + CW'(1));
          end
        end
      end
      S_SFIN: begin
        if (out_free) begin
          rsp_valid_d = 1'b1;
          if (have_pend_q) begin
            rsp_d = '{status: 1'b0, found: 1'b1, neighbor_vertex: pend_nb_q,
                      result_weight: pend_w_q, last: 1'b1};
          end else begin
            rsp_d = '{status: 1'b0, found: 1'b0, neighbor_vertex: '0,
                      result_weight: '1, last: 1'b1};
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      have_pend_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      have_pend_q <= have_pend_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    idx_q     <= idx_d;
    pend_nb_q <= pend_nb_d;
    pend_w_q  <= pend_w_d;
    rsp_q     <= rsp_d;
  end

  assign clearing_o    = (state_q == S_CLEAR);
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  `AMX_ASSERT_IMPL(a_clear_quiet, state_q == S_CLEAR, !rsp_valid_q && !pop_o,
                   "activity during the clearing pass")
  `AMX_ASSERT_IMPL(a_store_canon, ram_we, (ram_wdata == '1) || !ram_wdata[WeightBits-1],
                   "absent entry written as a value other than -1")
  `AMX_ASSERT_IMPL(a_scan_bound, state_q == S_SDATA, idx_q < cmd_q.n,
                   "scan index ran past the vertex count")
endmodule

### dv/adjacency_matrix_store_checker.sv
module adjacency_matrix_store_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  logic          req_ready_i,
  input  amx_pkg::req_t req_payload_i,
  input  logic          cfg_valid_i,
  input  logic          cfg_ready_i,
  input  amx_pkg::cfg_t cfg_payload_i,
  input  logic          rsp_valid_i,
  input  logic          rsp_ready_i,
  input  amx_pkg::rsp_t rsp_payload_i,
  output logic [31:0]   fail_count_o,
  output logic [31:0]   pending_o,
  output logic [31:0]   checked_o
);

  localparam int NV    = amx_pkg::DEF_MAX_VERTICES;
  localparam int W_IN  = amx_pkg::W_IN;
  localparam int W_OUT = amx_pkg::W_OUT;
  localparam int VTX_W = amx_pkg::VTX_W;
  localparam int CNT_W = amx_pkg::CNT_W;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;
  localparam logic signed [W_OUT-1:0] ABSENT     = -16'sd1;
  localparam logic signed [W_OUT-1:0] WEIGHT_TOP = 16'sh7FFF;
  localparam int REPORT_CAP = 20;

  // Shadow copy of the matrix and of the vertex count register.
  logic signed [W_OUT-1:0] arc_weight [NV][NV];
  logic [CNT_W-1:0]        vertex_count;
  amx_pkg::rsp_t           awaited_rsp_q [$];
  int                      fails;
  int                      checked;
  amx_pkg::rsp_t           got;
  amx_pkg::rsp_t           want;

  function automatic amx_pkg::rsp_t make_rsp(input logic st, input logic fnd,
                                             input logic [VTX_W-1:0] nb,
                                             input logic signed [W_OUT-1:0] w,
                                             input logic lst);
    amx_pkg::rsp_t r;
    r.status          = st;
    r.found           = fnd;
    r.neighbor_vertex = nb;
    r.result_weight   = w;
    r.last            = lst;
    return r;
  endfunction

  // Append one predicted result at the tail.
  function automatic void add_awaited(input amx_pkg::rsp_t r);
    awaited_rsp_q.insert(awaited_rsp_q.size(), r);
  endfunction

  function automatic logic signed [W_OUT-1:0] scanned_arc(input amx_pkg::req_t r, input int i);
    if (r.action == amx_pkg::ACT_SUCC) return arc_weight[r.source_vertex][i];
    return arc_weight[i][r.source_vertex];
  endfunction

  // Update the shadow matrix and queue every result the request causes.
  function automatic void apply_request(input amx_pkg::req_t r);
    logic [CNT_W-1:0]        n;
    logic signed [W_OUT-1:0] e;
    logic signed [W_OUT-1:0] v;
    logic signed [W_IN+1:0]  sum;
    int                      last_hit;
    n = (vertex_count > NV) ? CNT_W'(NV) : vertex_count;
    if (r.action > amx_pkg::ACT_PRED) return;
    if ({1'b0, r.source_vertex} >= n ||
        (r.action <= amx_pkg::ACT_READ && {1'b0, r.dest_vertex} >= n)) begin
      add_awaited(make_rsp(STATUS_RANGE, 1'b0, '0, ABSENT, 1'b1));
      return;
    end
    if (r.action <= amx_pkg::ACT_READ) begin
      e = arc_weight[r.source_vertex][r.dest_vertex];
      case (r.action)
        amx_pkg::ACT_SET: begin
          e = r.weight[W_IN-1] ? ABSENT : r.weight;
        end
        amx_pkg::ACT_REMOVE: begin
          e = ABSENT;
        end
        amx_pkg::ACT_ADD: begin
          sum = $signed({{2{e[W_OUT-1]}}, e}) + $signed({{2{r.weight[W_IN-1]}}, r.weight});
          // Negative sums (low clamp included) leave the arc absent.
          if (sum[W_IN+1]) e = ABSENT;
          else if (sum > $signed({2'b00, WEIGHT_TOP})) e = WEIGHT_TOP;
          else e = sum[W_OUT-1:0];
        end
        default: ;
      endcase
      arc_weight[r.source_vertex][r.dest_vertex] = e;
      add_awaited(make_rsp(STATUS_OK, ~e[W_OUT-1], r.dest_vertex, e, 1'b1));
      return;
    end
    last_hit = -1;
    for (int i = 0; i < n; i++) begin
      v = scanned_arc(r, i);
      if (!v[W_OUT-1]) last_hit = i;
    end
    if (last_hit < 0) begin
      add_awaited(make_rsp(STATUS_OK, 1'b0, '0, ABSENT, 1'b1));
      return;
    end
    for (int i = 0; i < n; i++) begin
      v = scanned_arc(r, i);
      if (!v[W_OUT-1]) begin
        add_awaited(make_rsp(STATUS_OK, 1'b1, VTX_W'(i), v, i == last_hit));
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NV; s++) begin
        for (int d = 0; d < NV; d++) arc_weight[s][d] = ABSENT;
      end
      vertex_count = amx_pkg::VC_RESET;
      awaited_rsp_q.delete();
      fails        = 0;
      checked      = 0;
      fail_count_o <= '0;
      pending_o    <= '0;
      checked_o    <= '0;
    end else begin
      // Compare before queueing, so a stray result never matches a fresh request.
      if (rsp_valid_i && rsp_ready_i) begin
        got = rsp_payload_i;
        if (awaited_rsp_q.size() == 0) begin
          fails++;
          if (fails <= REPORT_CAP)
            $display("%0t: unexpected result status=%0d found=%0d neighbor=%0d %s%0d last=%0d",
                     $time, got.status, got.found, got.neighbor_vertex, "weight=",
                     $signed(got.result_weight), got.last);
        end else begin
          want = awaited_rsp_q.pop_front();
          checked++;
          if (got.status !== want.status || got.found !== want.found ||
              got.neighbor_vertex !== want.neighbor_vertex ||
              got.result_weight !== want.result_weight || got.last !== want.last) begin
            fails++;
            if (fails <= REPORT_CAP) begin
              $display("%0t: mismatch expected status=%0d found=%0d neighbor=%0d %s%0d last=%0d",
                       $time, want.status, want.found, want.neighbor_vertex, "weight=",
                       $signed(want.result_weight), want.last);
              $display("%0t:          actual   status=%0d found=%0d neighbor=%0d %s%0d last=%0d",
                       $time, got.status, got.found, got.neighbor_vertex, "weight=",
                       $signed(got.result_weight), got.last);
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) vertex_count = cfg_payload_i.vertex_count;
      if (req_valid_i && req_ready_i) apply_request(req_payload_i);
      fail_count_o <= fails;
      pending_o    <= awaited_rsp_q.size();
      checked_o    <= checked;
    end
  end

endmodule

### dv/adjacency_matrix_store_core_tb.sv
module adjacency_matrix_store_core_tb;

  localparam int ACT_W = amx_pkg::ACT_W;
  localparam int VTX_W = amx_pkg::VTX_W;
  localparam int CNT_W = amx_pkg::CNT_W;
  localparam int W_IN  = amx_pkg::W_IN;

  localparam int RESET_CYCLES     = 12;
  localparam int IDLE_MAX         = 16;
  // Wait well past the longest scan before touching the register, since
  // ignored requests leave nothing to wait on.
  localparam int DRAIN_HOLD       = 40;
  // Covers the post-reset sweep plus stalls, many times over.
  localparam int STALL_LIMIT      = 4000;
  localparam int RANDOM_PER_PHASE = 30;
  localparam int PHASES           = 8;

  // Action codes the block ignores.
  localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd7;

  localparam logic signed [W_IN-1:0] W_MAX     = 16'sh7FFF;
  localparam logic signed [W_IN-1:0] W_MIN     = 16'sh8000;
  localparam logic signed [W_IN-1:0] W_NEG_ONE = -16'sd1;

  logic        clk_i;
  logic        rst_ni;
  logic [31:0] fail_count;
  logic [31:0] pending;
  logic [31:0] checked;
  int          req_gap_max = IDLE_MAX;
  int          rsp_gap_max = IDLE_MAX;
  int          sent_items  = 0;
  int          cfg_writes  = 0;
  int          stall_cycles = 0;

  amx_chan_if #(.payload_t(amx_pkg::req_t)) req_if ();
  amx_chan_if #(.payload_t(amx_pkg::cfg_t)) cfg_if ();
  amx_chan_if #(.payload_t(amx_pkg::rsp_t)) rsp_if ();

  adjacency_matrix_store_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .cfg_i  (cfg_if),
    .rsp_o  (rsp_if)
  );

  adjacency_matrix_store_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_if.valid),
    .req_ready_i   (req_if.ready),
    .req_payload_i (req_if.payload),
    .cfg_valid_i   (cfg_if.valid),
    .cfg_ready_i   (cfg_if.ready),
    .cfg_payload_i (cfg_if.payload),
    .rsp_valid_i   (rsp_if.valid),
    .rsp_ready_i   (rsp_if.ready),
    .rsp_payload_i (rsp_if.payload),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: end the run once nothing has moved on any channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Result sink: before each transfer, hold ready low for a random number of
  // cycles, then keep it high until the transfer happens.
  initial begin : rsp_sink
    int gap;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = $urandom_range(0, rsp_gap_max);
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
    end
  end

  function automatic amx_pkg::req_t req_of(input logic [ACT_W-1:0] act,
                                           input logic [VTX_W-1:0] src,
                                           input logic [VTX_W-1:0] dst,
                                           input logic signed [W_IN-1:0] w);
    amx_pkg::req_t r;
    r.action        = act;
    r.source_vertex = src;
    r.dest_vertex   = dst;
    r.weight        = w;
    return r;
  endfunction

  // Mix small values, the extremes and full-range noise.
  function automatic logic signed [W_IN-1:0] make_weight();
    logic signed [W_IN-1:0] w;
    case ($urandom_range(0, 3))
      0: w = W_IN'($urandom_range(0, 100));
      1: begin
        case ($urandom_range(0, 3))
          0: w = W_MAX;
          1: w = W_MIN;
          2: w = '0;
          default: w = W_NEG_ONE;
        endcase
      end
      2: w = W_IN'($urandom());
      default: w = -W_IN'($urandom_range(1, 100));
    endcase
    return w;
  endfunction

  // Mostly in-range indexes, so the matrix actually fills up.
  function automatic logic [VTX_W-1:0] pick_vertex(input int n_eff);
    if (n_eff > 0 && $urandom_range(0, 9) < 8)
      return VTX_W'($urandom_range(0, n_eff - 1));
    return VTX_W'($urandom_range(0, 15));
  endfunction

  function automatic amx_pkg::req_t random_request(input int n_eff);
    int               roll;
    logic [ACT_W-1:0] act;
    roll = $urandom_range(0, 99);
    if (roll < 30)      act = amx_pkg::ACT_SET;
    else if (roll < 45) act = amx_pkg::ACT_ADD;
    else if (roll < 55) act = amx_pkg::ACT_REMOVE;
    else if (roll < 70) act = amx_pkg::ACT_READ;
    else if (roll < 82) act = amx_pkg::ACT_SUCC;
    else if (roll < 94) act = amx_pkg::ACT_PRED;
    else if (roll < 97) act = ACT_SPARE_A;
    else                act = ACT_SPARE_B;
    return req_of(act, pick_vertex(n_eff), pick_vertex(n_eff), make_weight());
  endfunction

  // Wait a random gap, then hold valid high until the request transfers.
  // Valid stays high afterwards so back-to-back requests need no extra edge.
  task automatic send_request(input amx_pkg::req_t r);
    int gap;
    gap = $urandom_range(0, req_gap_max);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    sent_items++;
  endtask

  // Drop valid and wait until every predicted result has transferred.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Drain, then wait out DRAIN_HOLD; ignored requests are dropped in the front and start no scan.
  task automatic settle();
    drain_results();
    repeat (DRAIN_HOLD) @(posedge clk_i);
  endtask

  task automatic write_vertex_count(input logic [CNT_W-1:0] vc);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= vc;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 1'b0;
    cfg_writes++;
  endtask

  // Fill a whole row or column, then scan it, so scans reach their longest.
  task automatic fill_and_scan(input int n_eff);
    logic [VTX_W-1:0] hub;
    logic             by_column;
    hub       = pick_vertex(n_eff);
    by_column = 1'($urandom_range(0, 1));
    for (int d = 0; d < n_eff; d++) begin
      send_request(req_of(amx_pkg::ACT_SET, by_column ? VTX_W'(d) : hub,
                          by_column ? hub : VTX_W'(d),
                          W_IN'($urandom_range(0, 16'h7FFF))));
    end
    send_request(req_of(by_column ? amx_pkg::ACT_PRED : amx_pkg::ACT_SUCC, hub,
                        VTX_W'($urandom_range(0, 15)), make_weight()));
  endtask

  task automatic run_phase(input logic [CNT_W-1:0] vc, input int sel);
    int n_eff;
    settle();
    write_vertex_count(vc);
    n_eff = (vc > amx_pkg::DEF_MAX_VERTICES) ? amx_pkg::DEF_MAX_VERTICES : int'(vc);
    // Step through every pairing of busy and quiet sender and sink.
    req_gap_max = sel[0] ? IDLE_MAX : 0;
    rsp_gap_max = sel[1] ? IDLE_MAX : 0;
    fill_and_scan(n_eff);
    repeat (RANDOM_PER_PHASE) begin
      if ($urandom_range(0, 49) == 0) drain_results();
      send_request(random_request(n_eff));
    end
  endtask

  initial begin : stimulus
    logic [CNT_W-1:0] phase_counts [PHASES];
    rst_ni         <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.payload <= '0;
    // Zero, one, two, a random mid value, the full size and values past it.
    phase_counts[0] = 5'd1;
    phase_counts[1] = 5'd0;
    phase_counts[2] = 5'd31;
    phase_counts[3] = 5'd2;
    phase_counts[4] = 5'd17;
    phase_counts[5] = 5'd16;
    phase_counts[6] = CNT_W'($urandom_range(3, 15));
    phase_counts[7] = 5'd16;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Hold off until the clearing sweep is done and requests are taken.
    do @(posedge clk_i); while (!req_if.ready);
    write_vertex_count(amx_pkg::VC_RESET);

    // Directed part at full size: extremes, saturation, absent handling.
    send_request(req_of(amx_pkg::ACT_READ,   4'd0,  4'd0,  16'sd0));   // read of a cleared entry
    send_request(req_of(amx_pkg::ACT_SET,    4'd0,  4'd15, W_MAX));
    send_request(req_of(amx_pkg::ACT_SET,    4'd15, 4'd0,  16'sd0));   // zero weight is present
    send_request(req_of(amx_pkg::ACT_SET,    4'd3,  4'd3,  -16'sd5));  // negative set: absent
    send_request(req_of(amx_pkg::ACT_READ,   4'd3,  4'd3,  W_MAX));
    send_request(req_of(amx_pkg::ACT_SET,    4'd0,  4'd3,  16'sd100));
    send_request(req_of(amx_pkg::ACT_ADD,    4'd0,  4'd15, W_MAX));    // clamp at the top
    send_request(req_of(amx_pkg::ACT_ADD,    4'd0,  4'd3,  W_MIN));    // sum goes negative
    send_request(req_of(amx_pkg::ACT_ADD,    4'd2,  4'd2,  16'sd1));   // absent plus one is 0
    send_request(req_of(amx_pkg::ACT_ADD,    4'd2,  4'd3,  W_MIN));    // clamp at the bottom
    drain_results();
    send_request(req_of(amx_pkg::ACT_ADD,    4'd2,  4'd2,  W_NEG_ONE));
    send_request(req_of(amx_pkg::ACT_SET,    4'd15, 4'd15, 16'sh5555));
    send_request(req_of(amx_pkg::ACT_SUCC,   4'd0,  4'd9,  W_MIN));
    send_request(req_of(amx_pkg::ACT_SUCC,   4'd15, 4'd0,  W_MAX));
    send_request(req_of(amx_pkg::ACT_SUCC,   4'd5,  4'd15, 16'sd0));   // empty row
    send_request(req_of(amx_pkg::ACT_PRED,   4'd0,  4'd3,  16'sd0));
    send_request(req_of(amx_pkg::ACT_PRED,   4'd15, 4'd15, W_NEG_ONE));
    send_request(req_of(amx_pkg::ACT_PRED,   4'd3,  4'd0,  16'sd0));   // empty column
    send_request(req_of(ACT_SPARE_A,         4'd15, 4'd15, W_MIN));    // ignored
    send_request(req_of(ACT_SPARE_B,         4'd0,  4'd0,  W_MAX));    // ignored
    send_request(req_of(amx_pkg::ACT_REMOVE, 4'd0,  4'd15, W_MAX));
    send_request(req_of(amx_pkg::ACT_REMOVE, 4'd9,  4'd9,  16'sd0));   // already absent
    send_request(req_of(amx_pkg::ACT_READ,   4'd0,  4'd15, 16'sd0));
    send_request(req_of(amx_pkg::ACT_SUCC,   4'd0,  4'd0,  16'sd0));
    drain_results();

    for (int p = 0; p < PHASES; p++) run_phase(phase_counts[p], p);
    settle();

    $display("Covered %0d requests over %0d vertex-count writes (0, 1, 2, mid, 16, 17, 31);",
             sent_items, cfg_writes);
    $display("%0d results compared, %0d mismatches.", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
